[sv/clipped_line_rasterizer_core_assert.svh]
// ----------------------------------------------------------------------------
// Line rasterizer assertion macros
// Property wrappers for the rasterizer port checker.
// ----------------------------------------------------------------------------
`ifndef CLIPPED_LINE_RASTERIZER_CORE_ASSERT_SVH
`define CLIPPED_LINE_RASTERIZER_CORE_ASSERT_SVH

// same-cycle implication
`define CLR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CLR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/clr_pkg.sv]
// ----------------------------------------------------------------------------
// Line rasterizer package
// Item types, line classes, opcodes and register indexes.
// ----------------------------------------------------------------------------
package clr_pkg;

    localparam int COORD_BITS     = 16;
    localparam int SCREEN_BITS    = 15;
    localparam int COLOR_BITS     = 32;
    localparam int CFG_INDEX_BITS = 8;

    localparam logic [SCREEN_BITS-1:0] WIDTH_RESET  = SCREEN_BITS'(640);
    localparam logic [SCREEN_BITS-1:0] HEIGHT_RESET = SCREEN_BITS'(480);

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_WIDTH  = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] CFG_HEIGHT = CFG_INDEX_BITS'(1);

    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef enum logic [2:0] {
        CASE_POINT,
        CASE_VERT,
        CASE_HORZ,
        CASE_XMAJ,
        CASE_YMAJ
    } line_case_t;

    typedef struct packed {
        logic                  op;
        coord_t                x_start;
        coord_t                y_start;
        coord_t                x_end;
        coord_t                y_end;
        logic [COLOR_BITS-1:0] line_color;
    } cmd_t;

    typedef struct packed {
        coord_t                pixel_x;
        coord_t                pixel_y;
        logic [COLOR_BITS-1:0] pixel_color;
        logic                  visible;
        logic                  last_of_step;
        logic                  line_done;
    } pixel_t;

    // pixels of one step, slot 0 first
    typedef struct packed {
        logic [1:0]       count;
        pixel_t [2:0]     pixels;
    } step_result_t;

endpackage

[sv/clr_step.sv]
// ----------------------------------------------------------------------------
// Line rasterizer stepper
// Holds the line state; classifies on load and runs one iteration per step.
// ----------------------------------------------------------------------------
module clr_step (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                fire,
    input  clr_pkg::cmd_t                       cmd,
    input  logic [clr_pkg::SCREEN_BITS-1:0]     screen_width,
    input  logic [clr_pkg::SCREEN_BITS-1:0]     screen_height,
    output clr_pkg::step_result_t               result
);

    localparam int CB = clr_pkg::COORD_BITS;
    localparam int WB = CB + 1;
    localparam int DW = CB + 1;
    localparam int EW = CB + 2;
    localparam int VW = (WB > clr_pkg::SCREEN_BITS) ? WB : clr_pkg::SCREEN_BITS;

    // one spare bit so a minor overshoot past the range stays invisible
    typedef logic signed [WB-1:0] wcoord_t;

    logic                              active_reg, active_next;
    clr_pkg::line_case_t               line_case_reg, line_case_next;
    wcoord_t                           cur_x_reg, cur_x_next;
    wcoord_t                           cur_y_reg, cur_y_next;
    clr_pkg::coord_t                   end_x_reg, end_x_next;
    clr_pkg::coord_t                   end_y_reg, end_y_next;
    logic [DW-1:0]                     delta_major_reg, delta_major_next;
    logic [DW-1:0]                     delta_minor_reg, delta_minor_next;
    logic [EW-1:0]                     error_term_reg, error_term_next;
    logic                              step_sign_reg, step_sign_next;
    logic [clr_pkg::COLOR_BITS-1:0]    held_color_reg, held_color_next;

    function automatic clr_pkg::pixel_t make_pixel(
        input wcoord_t                          x,
        input wcoord_t                          y,
        input logic                             done,
        input logic [clr_pkg::COLOR_BITS-1:0]   color,
        input logic [clr_pkg::SCREEN_BITS-1:0]  w,
        input logic [clr_pkg::SCREEN_BITS-1:0]  h
    );
        clr_pkg::pixel_t p;
        p.pixel_x      = x[CB-1:0];
        p.pixel_y      = y[CB-1:0];
        p.pixel_color  = color;
        p.visible      = !x[WB-1] && (VW'($unsigned(x)) < VW'(w)) &&
                         !y[WB-1] && (VW'($unsigned(y)) < VW'(h));
        p.last_of_step = 1'b0;
        p.line_done    = done;
        return p;
    endfunction

    always_comb
    begin
        wcoord_t       x1, y1, x2, y2, tmp, inc, ex, ey, nx, ny;
        logic [DW-1:0] dx, dy;
        logic [EW-1:0] esum;
        logic [1:0]    idx;
        logic          emit;
        logic          xm;

        active_next      = active_reg;
        line_case_next   = line_case_reg;
        cur_x_next       = cur_x_reg;
        cur_y_next       = cur_y_reg;
        end_x_next       = end_x_reg;
        end_y_next       = end_y_reg;
        delta_major_next = delta_major_reg;
        delta_minor_next = delta_minor_reg;
        error_term_next  = error_term_reg;
        step_sign_next   = step_sign_reg;
        held_color_next  = held_color_reg;
        result           = '0;

        x1   = WB'(cmd.x_start);
        y1   = WB'(cmd.y_start);
        x2   = WB'(cmd.x_end);
        y2   = WB'(cmd.y_end);
        dx   = (x1 < x2) ? DW'(x2 - x1) : DW'(x1 - x2);
        dy   = (y1 < y2) ? DW'(y2 - y1) : DW'(y1 - y2);
        tmp  = '0;
        inc  = step_sign_reg ? '1 : WB'(1);
        ex   = WB'(end_x_reg);
        ey   = WB'(end_y_reg);
        nx   = cur_x_reg;
        ny   = cur_y_reg;
        esum = error_term_reg + EW'(delta_minor_reg);
        idx  = 2'd0;
        emit = 1'b0;
        xm   = (line_case_reg == clr_pkg::CASE_XMAJ);

        if (fire && cmd.op == clr_pkg::OP_LOAD)
        begin
            held_color_next  = cmd.line_color;
            error_term_next  = '0;
            active_next      = 1'b1;
            delta_major_next = (dx > dy) ? dx : dy;
            delta_minor_next = '0;
            if (x1 == x2 && y1 == y2)
            begin
                line_case_next = clr_pkg::CASE_POINT;
                step_sign_next = 1'b0;
            end
            else if (x1 == x2)
            begin
                line_case_next = clr_pkg::CASE_VERT;
                step_sign_next = (y2 < y1);
            end
            else if (y1 == y2)
            begin
                line_case_next = clr_pkg::CASE_HORZ;
                step_sign_next = (x2 < x1);
            end
            else if (dx >= dy)
            begin
                line_case_next = clr_pkg::CASE_XMAJ;
                if (x2 < x1)
                begin
                    tmp = x1; x1 = x2; x2 = tmp;
                    tmp = y1; y1 = y2; y2 = tmp;
                end
                step_sign_next   = (y2 < y1);
                delta_major_next = dx;
                delta_minor_next = dy;
            end
            else
            begin
                line_case_next = clr_pkg::CASE_YMAJ;
                if (y2 < y1)
                begin
                    tmp = x1; x1 = x2; x2 = tmp;
                    tmp = y1; y1 = y2; y2 = tmp;
                end
                step_sign_next   = (x2 < x1);
                delta_major_next = dy;
                delta_minor_next = dx;
            end
            cur_x_next = x1;
            cur_y_next = y1;
            end_x_next = x2[CB-1:0];
            end_y_next = y2[CB-1:0];
        end
        else if (fire && active_reg)
        begin
            emit = 1'b1;
            result.pixels[0] = make_pixel(cur_x_reg, cur_y_reg, 1'b0, held_color_reg,
                                          screen_width, screen_height);
            case (line_case_reg)
                clr_pkg::CASE_POINT:
                begin
                    result.pixels[0].line_done = 1'b1;
                    active_next = 1'b0;
                end
                clr_pkg::CASE_VERT, clr_pkg::CASE_HORZ:
                begin
                    if (line_case_reg == clr_pkg::CASE_VERT)
                        ny = cur_y_reg + inc;
                    else
                        nx = cur_x_reg + inc;
                    if (nx == ex && ny == ey)
                    begin
                        idx = 2'd1;
                        result.pixels[1] = make_pixel(ex, ey, 1'b1, held_color_reg,
                                                      screen_width, screen_height);
                        active_next = 1'b0;
                    end
                    cur_x_next = nx;
                    cur_y_next = ny;
                end
                clr_pkg::CASE_XMAJ, clr_pkg::CASE_YMAJ:
                begin
                    if (esum >= EW'(delta_major_reg))
                    begin
                        error_term_next = esum - EW'(delta_major_reg);
                        if (xm)
                            ny = cur_y_reg + inc;
                        else
                            nx = cur_x_reg + inc;
                        idx = 2'd1;
                        result.pixels[1] = make_pixel(nx, ny, 1'b0, held_color_reg,
                                                      screen_width, screen_height);
                    end
                    else
                    begin
                        error_term_next = esum;
                    end
                    if (xm ? (nx == ex) : (ny == ey))
                    begin
                        idx = idx + 2'd1;
                        result.pixels[idx] = make_pixel(ex, ey, 1'b1, held_color_reg,
                                                        screen_width, screen_height);
                        active_next = 1'b0;
                    end
                    else if (xm)
                    begin
                        nx = nx + WB'(1);
                    end
                    else
                    begin
                        ny = ny + WB'(1);
                    end
                    cur_x_next = nx;
                    cur_y_next = ny;
                end
                default:
                begin
                    emit        = 1'b0;
                    active_next = 1'b0;
                end
            endcase
            if (emit)
            begin
                result.count = idx + 2'd1;
                result.pixels[idx].last_of_step = 1'b1;
            end
            else
            begin
                result = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg      <= 1'b0;
            line_case_reg   <= clr_pkg::CASE_POINT;
            cur_x_reg       <= '0;
            cur_y_reg       <= '0;
            end_x_reg       <= '0;
            end_y_reg       <= '0;
            delta_major_reg <= '0;
            delta_minor_reg <= '0;
            error_term_reg  <= '0;
            step_sign_reg   <= 1'b0;
            held_color_reg  <= '0;
        end
        else
        begin
            active_reg      <= active_next;
            line_case_reg   <= line_case_next;
            cur_x_reg       <= cur_x_next;
            cur_y_reg       <= cur_y_next;
            end_x_reg       <= end_x_next;
            end_y_reg       <= end_y_next;
            delta_major_reg <= delta_major_next;
            delta_minor_reg <= delta_minor_next;
            error_term_reg  <= error_term_next;
            step_sign_reg   <= step_sign_next;
            held_color_reg  <= held_color_next;
        end
    end

endmodule

[sv/clr_outq.sv]
// ----------------------------------------------------------------------------
// Line rasterizer result buffer
// Holds the pixels of one step; one leaves per cycle while pix_stall is low.
// ----------------------------------------------------------------------------
module clr_outq (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr,
    input  clr_pkg::step_result_t result,
    input  logic                  pix_stall,
    output logic                  pix_valid,
    output clr_pkg::pixel_t       pix,
    output logic                  hold
);

    logic [1:0]      cnt_reg, cnt_next;
    clr_pkg::pixel_t slot_reg [3];
    logic            pop;

    assign pix_valid = (cnt_reg != 2'd0);
    assign pix       = slot_reg[0];
    assign pop       = pix_valid && !pix_stall;
    // room for a new step only once the last pending pixel leaves
    assign hold      = (cnt_reg > 2'd1) || (cnt_reg == 2'd1 && pix_stall);

    always_comb
    begin
        cnt_next = cnt_reg;
        if (wr)
            cnt_next = result.count;
        else if (pop)
            cnt_next = cnt_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            slot_reg[0] <= result.pixels[0];
            slot_reg[1] <= result.pixels[1];
            slot_reg[2] <= result.pixels[2];
        end
        else if (pop)
        begin
            slot_reg[0] <= slot_reg[1];
            slot_reg[1] <= slot_reg[2];
        end
    end

endmodule

[sv/clipped_line_rasterizer_core.sv]
// ----------------------------------------------------------------------------
// Clipped line rasterizer core
// Bresenham line stepper with screen-bounds visibility per pixel.
// ----------------------------------------------------------------------------
//  Channel  | Dir | Handshake             | Carries
//  cmd      | in  | cmd_valid / cmd_stall | load or step item
//  pix      | out | pix_valid / pix_stall | one pixel item
//  cfg      | in  | cfg_valid / cfg_ready | register index and data
//
//  A step is worked out in the cycle it is accepted; its one to three pixels
//  leave the result buffer one per cycle while pix_stall is low, the first
//  in the cycle after. A load gives no pixel. With pix_stall low, steps that
//  give one pixel run one per cycle; others stall cmd till the last leaves.
//  Reset idles the line, empties the buffer, and sets the screen to 640x480.
//  cmd_stall rises while more than one pixel is pending, or one is stalled.
// ----------------------------------------------------------------------------
module clipped_line_rasterizer_core (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cmd_valid,
    output logic                                  cmd_stall,
    input  clr_pkg::cmd_t                         cmd,
    output logic                                  pix_valid,
    input  logic                                  pix_stall,
    output clr_pkg::pixel_t                       pix,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [clr_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [clr_pkg::SCREEN_BITS-1:0]       cfg_data
);

    logic [clr_pkg::SCREEN_BITS-1:0] screen_width_reg;
    logic [clr_pkg::SCREEN_BITS-1:0] screen_height_reg;
    clr_pkg::step_result_t           result;
    logic                            fire;
    logic                            hold;

    assign cfg_ready = 1'b1;
    assign cmd_stall = hold;
    assign fire      = cmd_valid && !hold;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_width_reg  <= clr_pkg::WIDTH_RESET;
            screen_height_reg <= clr_pkg::HEIGHT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == clr_pkg::CFG_WIDTH)
                screen_width_reg <= cfg_data;
            else if (cfg_index == clr_pkg::CFG_HEIGHT)
                screen_height_reg <= cfg_data;
        end
    end

    clr_step u_step (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (fire),
        .cmd           (cmd),
        .screen_width  (screen_width_reg),
        .screen_height (screen_height_reg),
        .result        (result)
    );

    clr_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (fire),
        .result    (result),
        .pix_stall (pix_stall),
        .pix_valid (pix_valid),
        .pix       (pix),
        .hold      (hold)
    );

endmodule

[sv/clr_checker.sv]
// ----------------------------------------------------------------------------
// Line rasterizer port checker
// Port-level properties, bound to the core.
// ----------------------------------------------------------------------------
`include "clipped_line_rasterizer_core_assert.svh"

module clr_checker (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cmd_valid,
    input  logic                                  cmd_stall,
    input  clr_pkg::cmd_t                         cmd,
    input  logic                                  pix_valid,
    input  logic                                  pix_stall,
    input  clr_pkg::pixel_t                       pix
);

    `CLR_ASSERT_NEXT(a_pix_hold, pix_valid && pix_stall, pix_valid && $stable(pix),
                     "pixel item changed while stalled")
    `CLR_ASSERT_NEXT(a_load_silent,
                     !pix_valid && cmd_valid && !cmd_stall && cmd.op == clr_pkg::OP_LOAD,
                     !pix_valid, "load produced a pixel")
    `CLR_ASSERT_NOW(a_done_last, pix_valid && pix.line_done, pix.last_of_step,
                    "line end not last of its step")
    `CLR_ASSERT_NOW(a_stall_busy, cmd_stall, pix_valid,
                    "command stalled with no pixel pending")
    `CLR_ASSERT_NOW(a_vis_sign, pix_valid && pix.visible,
                    !pix.pixel_x[clr_pkg::COORD_BITS-1] && !pix.pixel_y[clr_pkg::COORD_BITS-1],
                    "negative pixel flagged visible")

endmodule

bind clipped_line_rasterizer_core clr_checker u_clr_checker (.*);
